// ----- rtl/core/multicast_join_prune_aggregator_core_assert.svh -----
// assertion macros for the join/prune aggregator core
// included by rtl modules that carry concurrent checks
`ifndef MULTICAST_JOIN_PRUNE_AGGREGATOR_CORE_ASSERT_SVH
`define MULTICAST_JOIN_PRUNE_AGGREGATOR_CORE_ASSERT_SVH
`define MJPA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MJPA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ----- rtl/core/mjpa_pkg.sv -----
// package for the join/prune aggregator: sizes, codes, payload types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mjpa_pkg;
   localparam int MAX_GROUPS = 16;
   localparam int MAX_SRC = 8;
   localparam int LISTS_PER_GROUP = 8;
   localparam int GW = $clog2(MAX_GROUPS);
   localparam int SW = $clog2(MAX_SRC);
   localparam int LW = $clog2(MAX_GROUPS * LISTS_PER_GROUP);
   localparam int MW = $clog2(MAX_GROUPS * LISTS_PER_GROUP * MAX_SRC);

   localparam logic [1:0] ST_APPENDED = 2'd0;
   localparam logic [1:0] ST_IGNORED = 2'd1;
   localparam logic [1:0] ST_CONFLICT = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   localparam logic [1:0] K_RP = 2'd0;
   localparam logic [1:0] K_WC = 2'd1;
   localparam logic [1:0] K_SGRPT = 2'd2;
   localparam logic [1:0] K_SG = 2'd3;

   localparam logic OP_ADD = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam logic [15:0] HOLD_RESET = 16'd210;

   typedef struct packed {
      logic        opcode;
      logic [31:0] source_address;
      logic [31:0] group_address;
      logic [5:0]  group_mask_length;
      logic [1:0]  entry_kind;
      logic        is_prune;
      logic [15:0] new_holdtime;
      logic        force_new_group;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  group_slot;
      logic [4:0]  groups_in_use;
      logic [5:0]  group_join_count;
      logic [5:0]  group_prune_count;
      logic [15:0] holdtime_now;
   } rsp_type;
endpackage
`default_nettype wire

// ----- rtl/core/mjpa_req_if.sv -----
// word channel interface for requests
// depends on mjpa_pkg
`timescale 1ns / 1ps
`default_nettype none
interface mjpa_req_if;
   import mjpa_pkg::*;
   logic    valid;
   logic    ready;
   req_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/mjpa_rsp_if.sv -----
// response word channel interface
// depends on mjpa_pkg
`timescale 1ns / 1ps
`default_nettype none
interface mjpa_rsp_if;
   import mjpa_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/multicast_join_prune_aggregator_core.sv -----
// multicast join/prune aggregator top level with sequencer and table memories
// depends on mjpa_pkg, mjpa_req_if, mjpa_rsp_if and the assertion header
//
// usage: one request word enters on req (valid/ready), one response word
// leaves on rsp. csr is an apb-style port with default_holdtime at byte 0.
// one shared 32-bit comparator walks the group table record by record
// and then each source list to be checked entry by entry, up to its first
// hit (one memory read port). removals shift a list down entry by entry.
// an add searches the groups, scans the lists, then removes and appends
// where the rules allow before its response; a clear goes from idle
// straight to the done state, which registers the response.
// req is not ready while a word is in work.
// after reset the block is ready at once: list lengths and counts sit in
// flip-flops cleared by reset, group records and source entries are only
// read below the held lengths. when rsp is stalled the response is held
// in its output register and the next request waits until it is taken.
// holdtime_now reflects the stored holdtime, which an add overwrites when it
// finds or creates a group, even if the entry is ignored or its list is full.
`timescale 1ns / 1ps
`default_nettype none
module multicast_join_prune_aggregator_core (
   input  wire          clock,
   input  wire          reset,
   mjpa_req_if.sink     req,
   mjpa_rsp_if.source   rsp,
   input  wire          csr_psel,
   input  wire          csr_penable,
   input  wire          csr_pwrite,
   input  wire  [0:0]   csr_paddr,
   input  wire  [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import mjpa_pkg::*;
   `include "multicast_join_prune_aggregator_core_assert.svh"

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SEARCH = 4'd1;
   localparam logic [3:0] S_GRP = 4'd2;
   localparam logic [3:0] S_SCAN = 4'd3;
   localparam logic [3:0] S_SCMP = 4'd4;
   localparam logic [3:0] S_DECIDE = 4'd5;
   localparam logic [3:0] S_DROP = 4'd6;
   localparam logic [3:0] S_DCMP = 4'd7;
   localparam logic [3:0] S_SHIFT = 4'd8;
   localparam logic [3:0] S_SWR = 4'd9;
   localparam logic [3:0] S_APPEND = 4'd10;
   localparam logic [3:0] S_DONE = 4'd11;

   // checks: found bits per list code kind*2+prune
   localparam int NCHK = 8;

   logic [3:0]  state_ff, state_in;
   req_type     item_ff;
   logic [15:0] dflt_ff;
   logic [15:0] hold_ff;
   logic [GW:0] gcnt_ff;
   logic [GW-1:0] g_ff;
   logic [GW:0] gi_ff;
   logic [LISTS_PER_GROUP*(SW+1)-1:0] len_ff [MAX_GROUPS];
   logic [5:0]  jcnt_ff [MAX_GROUPS];
   logic [5:0]  pcnt_ff [MAX_GROUPS];
   logic [31:0] gaddr_mem [MAX_GROUPS];
   logic [5:0]  gmask_mem [MAX_GROUPS];
   logic [31:0] src_mem [MAX_GROUPS*LISTS_PER_GROUP*MAX_SRC];
   logic [31:0] grd_ff, srd_ff;
   logic [5:0]  mrd_ff;
   logic [NCHK-1:0] found_ff;
   logic [NCHK-1:0] todo_ff;
   logic [2:0]  code_ff;
   logic [SW:0] idx_ff;
   logic [SW:0] pos_ff;
   logic [1:0]  dtodo_ff;
   logic [1:0]  status_ff;
   logic        rvalid_ff;
   rsp_type     rword_ff;
   logic        valid_grp_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = {16'd0, dflt_ff};
   wire csr_wr = csr_psel & csr_penable & csr_pwrite & csr_pready;

   assign req.ready = (state_ff == S_IDLE) && !rvalid_ff;
   assign rsp.valid = rvalid_ff;
   assign rsp.word = rword_ff;

   wire [LW-1:0] lid = {g_ff, code_ff};
   wire [MW-1:0] saddr = {lid, idx_ff[SW-1:0]};
   wire [SW:0]   cur_len = len_ff[g_ff][int'(code_ff)*(SW+1) +: (SW+1)];
   wire          item_prn = item_ff.is_prune;
   wire [2:0]    tgt_code = {item_ff.entry_kind, item_prn};
   wire [SW:0]   tgt_len = len_ff[g_ff][int'(tgt_code)*(SW+1) +: (SW+1)];

   // found bit helper for the rule decision
   function automatic logic fb(input logic [NCHK-1:0] f, input logic [1:0] k,
                               input logic p);
      fb = f[{k, p}];
   endfunction

   logic [1:0] rule_st;
   always_comb begin
      rule_st = ST_APPENDED;
      unique case (item_ff.entry_kind)
         K_RP: if (fb(found_ff, K_RP, item_prn)) rule_st = ST_IGNORED;
         K_WC: begin
            if (!item_prn) begin
               if (fb(found_ff, K_WC, 1'b0)) rule_st = ST_IGNORED;
               else if (fb(found_ff, K_WC, 1'b1)) rule_st = ST_CONFLICT;
            end else begin
               if (fb(found_ff, K_WC, 1'b0)) rule_st = ST_CONFLICT;
               else if (fb(found_ff, K_WC, 1'b1)) rule_st = ST_IGNORED;
            end
         end
         K_SGRPT: begin
            if (!item_prn) begin
               if (fb(found_ff, K_WC, 1'b0) || fb(found_ff, K_WC, 1'b1) ||
                   fb(found_ff, K_SGRPT, 1'b0)) rule_st = ST_IGNORED;
               else if (fb(found_ff, K_SGRPT, 1'b1)) rule_st = ST_CONFLICT;
            end else begin
               if (fb(found_ff, K_WC, 1'b1)) rule_st = ST_IGNORED;
               else if (fb(found_ff, K_SGRPT, 1'b0)) rule_st = ST_CONFLICT;
               else if (fb(found_ff, K_SGRPT, 1'b1) || fb(found_ff, K_SG, 1'b0) ||
                        fb(found_ff, K_SG, 1'b1)) rule_st = ST_IGNORED;
            end
         end
         default: begin
            if (!item_prn) begin
               if (fb(found_ff, K_SG, 1'b0)) rule_st = ST_IGNORED;
               else if (fb(found_ff, K_SG, 1'b1)) rule_st = ST_CONFLICT;
            end else begin
               if (fb(found_ff, K_SG, 1'b0)) rule_st = ST_CONFLICT;
               else if (fb(found_ff, K_SG, 1'b1)) rule_st = ST_IGNORED;
            end
         end
      endcase
   end

   // lists to scan: all those the rules might consult
   logic [NCHK-1:0] scan_set;
   always_comb begin
      scan_set = '0;
      case (item_ff.entry_kind)
         K_RP: scan_set[{K_RP, item_prn}] = 1'b1;
         K_WC: begin
            scan_set[{K_WC, 1'b0}] = 1'b1;
            scan_set[{K_WC, 1'b1}] = 1'b1;
         end
         K_SGRPT: begin
            scan_set[{K_WC, 1'b0}] = 1'b1;
            scan_set[{K_WC, 1'b1}] = 1'b1;
            scan_set[{K_SGRPT, 1'b0}] = 1'b1;
            scan_set[{K_SGRPT, 1'b1}] = 1'b1;
            scan_set[{K_SG, 1'b0}] = 1'b1;
            scan_set[{K_SG, 1'b1}] = 1'b1;
         end
         default: begin
            scan_set[{K_SG, 1'b0}] = 1'b1;
            scan_set[{K_SG, 1'b1}] = 1'b1;
         end
      endcase
   end

   // removal lists: bit0 sgrpt join, bit1 sgrpt prune
   logic [1:0] drop_set;
   always_comb begin
      drop_set = '0;
      if (item_ff.entry_kind == K_WC) begin
         drop_set[0] = 1'b1;
         drop_set[1] = item_prn;
      end else if (item_ff.entry_kind == K_SG) begin
         drop_set[1] = 1'b1;
      end
   end

   // lowest set bit
   function automatic logic [2:0] low8(input logic [NCHK-1:0] v);
      logic [2:0] r;
      r = '0;
      for (int i = NCHK - 1; i >= 0; i--) begin
         if (v[i]) r = 3'(i);
      end
      low8 = r;
   endfunction

   // shared comparator
   logic [31:0] cmp_a, cmp_b;
   always_comb begin
      cmp_a = (state_ff == S_GRP) ? grd_ff : srd_ff;
      cmp_b = (state_ff == S_GRP) ? item_ff.group_address : item_ff.source_address;
   end
   wire cmp_eq = (cmp_a == cmp_b);
   wire cmp_hit = cmp_eq &&
                  ((state_ff != S_GRP) || (mrd_ff == item_ff.group_mask_length));

   logic [1:0] fin_st;
   logic       fin_valid;

   always_comb begin
      state_in = state_ff;
      fin_st = status_ff;
      fin_valid = valid_grp_ff;
      unique case (state_ff)
         S_IDLE: if (req.valid && req.ready) begin
            if (req.word.opcode == OP_CLEAR) state_in = S_DONE;
            else if (req.word.force_new_group) state_in = S_SCAN;
            else state_in = S_SEARCH;
         end
         S_SEARCH: state_in = (gi_ff < gcnt_ff) ? S_GRP : S_SCAN;
         S_GRP: state_in = cmp_hit ? S_SCAN : S_SEARCH;
         S_SCAN: begin
            if (!valid_grp_ff) state_in = S_DONE;
            else if (todo_ff == '0) state_in = S_DECIDE;
            else if (idx_ff < cur_len) state_in = S_SCMP;
            else state_in = S_SCAN;
         end
         S_SCMP: state_in = S_SCAN;
         S_DECIDE: begin
            if (rule_st != ST_APPENDED) state_in = S_DONE;
            else if (tgt_len >= (SW+1)'(MAX_SRC)) state_in = S_DONE;
            else state_in = S_DROP;
         end
         S_DROP: begin
            if (dtodo_ff == '0) state_in = S_APPEND;
            else if (idx_ff < cur_len) state_in = S_DCMP;
            else state_in = S_DROP;
         end
         S_DCMP: state_in = cmp_hit ? S_SHIFT : S_DROP;
         S_SHIFT: state_in = (pos_ff + 1'b1 < cur_len) ? S_SWR : S_DROP;
         S_SWR: state_in = S_SHIFT;
         S_APPEND: state_in = S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dflt_ff <= HOLD_RESET;
         hold_ff <= HOLD_RESET;
         gcnt_ff <= '0;
         rvalid_ff <= 1'b0;
         for (int i = 0; i < MAX_GROUPS; i++) begin
            len_ff[i] <= '0;
            jcnt_ff[i] <= '0;
            pcnt_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_wr && csr_paddr == 1'b0) dflt_ff <= csr_pwdata[15:0];
         if (rvalid_ff && rsp.ready) rvalid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req.valid && req.ready) begin
               item_ff <= req.word;
               gi_ff <= '0;
               idx_ff <= '0;
               found_ff <= '0;
               if (req.word.opcode == OP_CLEAR || !req.word.force_new_group) begin
                  g_ff <= '0;
                  status_ff <= ST_APPENDED;
                  valid_grp_ff <= 1'b0;
               end
               if (req.word.opcode == OP_CLEAR) begin
                  gcnt_ff <= '0;
                  hold_ff <= dflt_ff;
                  for (int i = 0; i < MAX_GROUPS; i++) begin
                     len_ff[i] <= '0;
                     jcnt_ff[i] <= '0;
                     pcnt_ff[i] <= '0;
                  end
               end
            end
            S_SEARCH: if (gi_ff < gcnt_ff) begin
               grd_ff <= gaddr_mem[gi_ff[GW-1:0]];
               mrd_ff <= gmask_mem[gi_ff[GW-1:0]];
            end
            S_GRP: if (cmp_hit) begin
               g_ff <= gi_ff[GW-1:0];
               valid_grp_ff <= 1'b1;
               hold_ff <= item_ff.new_holdtime;
               todo_ff <= scan_set;
               code_ff <= low8(scan_set);
            end else begin
               gi_ff <= gi_ff + 1'b1;
            end
            default: ;
         endcase
         // entering scan without a hit: create a group or report full
         if ((state_ff == S_SEARCH && !(gi_ff < gcnt_ff)) ||
             (state_ff == S_IDLE && req.valid && req.ready &&
              req.word.opcode == OP_ADD && req.word.force_new_group)) begin
            if (gcnt_ff >= (GW+1)'(MAX_GROUPS)) begin
               status_ff <= ST_FULL;
               valid_grp_ff <= 1'b0;
               g_ff <= '0;
            end else begin
               status_ff <= ST_APPENDED;
               g_ff <= gcnt_ff[GW-1:0];
               gaddr_mem[gcnt_ff[GW-1:0]] <= (state_ff == S_IDLE) ?
                  req.word.group_address : item_ff.group_address;
               gmask_mem[gcnt_ff[GW-1:0]] <= (state_ff == S_IDLE) ?
                  req.word.group_mask_length : item_ff.group_mask_length;
               jcnt_ff[gcnt_ff[GW-1:0]] <= '0;
               pcnt_ff[gcnt_ff[GW-1:0]] <= '0;
               len_ff[gcnt_ff[GW-1:0]] <= '0;
               gcnt_ff <= gcnt_ff + 1'b1;
               valid_grp_ff <= 1'b1;
               hold_ff <= (state_ff == S_IDLE) ? req.word.new_holdtime
                                                : item_ff.new_holdtime;
               if (state_ff == S_IDLE) begin
                  todo_ff <= '0;
                  code_ff <= '0;
               end else begin
                  todo_ff <= '0;
               end
            end
         end
         unique case (state_ff)
            S_SCAN: if (valid_grp_ff && todo_ff != '0) begin
               if (idx_ff < cur_len) begin
                  srd_ff <= src_mem[saddr];
               end else begin
                  todo_ff[code_ff] <= 1'b0;
                  code_ff <= low8(todo_ff & ~(NCHK'(1) << code_ff));
                  idx_ff <= '0;
               end
            end
            S_SCMP: begin
               if (cmp_hit) begin
                  found_ff[code_ff] <= 1'b1;
                  todo_ff[code_ff] <= 1'b0;
                  code_ff <= low8(todo_ff & ~(NCHK'(1) << code_ff));
                  idx_ff <= '0;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_DECIDE: begin
               status_ff <= (rule_st != ST_APPENDED) ? rule_st :
                  (tgt_len >= (SW+1)'(MAX_SRC)) ? ST_FULL : ST_APPENDED;
               dtodo_ff <= drop_set;
               code_ff <= drop_set[0] ? {K_SGRPT, 1'b0} : {K_SGRPT, 1'b1};
               idx_ff <= '0;
            end
            S_DROP: begin
               if (dtodo_ff != '0) begin
                  if (idx_ff < cur_len) begin
                     srd_ff <= src_mem[saddr];
                  end else begin
                     dtodo_ff[code_ff[0]] <= 1'b0;
                     code_ff <= {K_SGRPT, 1'b1};
                     idx_ff <= '0;
                  end
               end
            end
            S_DCMP: begin
               if (cmp_hit) pos_ff <= idx_ff;
               else idx_ff <= idx_ff + 1'b1;
            end
            S_SHIFT: begin
               if (pos_ff + 1'b1 < cur_len) begin
                  srd_ff <= src_mem[{lid, SW'(pos_ff + 1'b1)}];
               end else begin
                  len_ff[g_ff][int'(code_ff)*(SW+1) +: (SW+1)] <= cur_len - 1'b1;
                  if (code_ff[0]) begin
                     if (pcnt_ff[g_ff] != '0) pcnt_ff[g_ff] <= pcnt_ff[g_ff] - 1'b1;
                  end else begin
                     if (jcnt_ff[g_ff] != '0) jcnt_ff[g_ff] <= jcnt_ff[g_ff] - 1'b1;
                  end
                  dtodo_ff[code_ff[0]] <= 1'b0;
                  code_ff <= {K_SGRPT, 1'b1};
                  idx_ff <= '0;
               end
            end
            S_SWR: begin
               src_mem[{lid, pos_ff[SW-1:0]}] <= srd_ff;
               pos_ff <= pos_ff + 1'b1;
            end
            S_APPEND: begin
               src_mem[{g_ff, tgt_code, tgt_len[SW-1:0]}] <= item_ff.source_address;
               len_ff[g_ff][int'(tgt_code)*(SW+1) +: (SW+1)] <= tgt_len + 1'b1;
               if (item_prn) pcnt_ff[g_ff] <= pcnt_ff[g_ff] + 1'b1;
               else jcnt_ff[g_ff] <= jcnt_ff[g_ff] + 1'b1;
            end
            S_DONE: begin
               rvalid_ff <= 1'b1;
               rword_ff.status <= fin_st;
               rword_ff.group_slot <= fin_valid ? 4'(g_ff) : 4'd0;
               rword_ff.groups_in_use <= 5'(gcnt_ff);
               rword_ff.group_join_count <= fin_valid ? jcnt_ff[g_ff] : 6'd0;
               rword_ff.group_prune_count <= fin_valid ? pcnt_ff[g_ff] : 6'd0;
               rword_ff.holdtime_now <= hold_ff;
            end
            default: ;
         endcase
      end
   end

   `MJPA_ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != S_IDLE, !req.ready)
   `MJPA_ASSERT_NEXT(a_done_gives_rsp, clock, reset, state_ff == S_DONE, rvalid_ff)
   `MJPA_ASSERT_IMP(a_gcnt_range, clock, reset, 1'b1, gcnt_ff <= (GW+1)'(MAX_GROUPS))
   `MJPA_ASSERT_IMP(a_append_room, clock, reset, state_ff == S_APPEND, tgt_len < (SW+1)'(MAX_SRC))
endmodule
`default_nettype wire
